/* design/nearest_point_distance_macros.svh */
// ---------------------------------------------------------------------------
// Nearest point distance: assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef NEAREST_POINT_DISTANCE_MACROS_SVH
`define NEAREST_POINT_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npd assertion failed");
// next-cycle implication
`define NPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npd assertion failed");
`else
`define NPD_ASSERT_IMPL(lbl, ante, cons)
`define NPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/npd_pkg.sv */
// ---------------------------------------------------------------------------
// Nearest point distance package
// Sizes, mode codes and control structs shared by the block's files.
// ---------------------------------------------------------------------------
package npd_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int RT_W   = COORD_BITS + 1;
  localparam int SQ_W   = 2 * RT_W;
  localparam int DIST_W = 25;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic start;  // new query: forget the running minimum
    logic valid;  // RAM read data carries a stored point
  } npd_scan_ctl_t;

  typedef struct packed {
    logic busy;   // a point is still in the distance pipeline
    logic found;  // at least one point compared since start
  } npd_scan_sts_t;

endpackage

/* design/npd_in_if.sv */
// ---------------------------------------------------------------------------
// Nearest point distance request channel
// Valid/ready channel carrying mode and point coordinates.
// ---------------------------------------------------------------------------
interface npd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [npd_pkg::COORD_BITS-1:0] easting;
  logic [npd_pkg::COORD_BITS-1:0] northing;

  modport source (output valid, mode, easting, northing, input ready);
  modport sink   (input valid, mode, easting, northing, output ready);
endinterface

/* design/npd_out_if.sv */
// ---------------------------------------------------------------------------
// Nearest point distance result channel
// Valid/ready channel carrying the query result.
// ---------------------------------------------------------------------------
interface npd_out_if;
  logic                        valid;
  logic                        ready;
  logic [npd_pkg::DIST_W-1:0]  distance;
  logic                        table_empty;
  logic                        overflowed;

  modport source (output valid, distance, table_empty, overflowed, input ready);
  modport sink   (input valid, distance, table_empty, overflowed, output ready);
endinterface

/* design/npd_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module npd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/npd_dist.sv */
// ---------------------------------------------------------------------------
// Nearest point distance: squared distance pipeline
// Absolute difference, square, sum, then running minimum (first one kept).
// ---------------------------------------------------------------------------
module npd_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  npd_pkg::npd_scan_ctl_t          ctl_i,
  input  logic [npd_pkg::COORD_BITS-1:0]  ref_e_i,
  input  logic [npd_pkg::COORD_BITS-1:0]  ref_n_i,
  input  logic [npd_pkg::COORD_BITS-1:0]  qry_e_i,
  input  logic [npd_pkg::COORD_BITS-1:0]  qry_n_i,
  output npd_pkg::npd_scan_sts_t          sts_o,
  output logic [npd_pkg::SQ_W-1:0]        best_o
);

  localparam int CB = npd_pkg::COORD_BITS;
  localparam int SW = npd_pkg::SQ_W;

  logic              v1_q, v2_q, v3_q, found_q;
  logic [CB-1:0]     dx_q, dy_q;
  logic [2*CB-1:0]   sqx_q, sqy_q;
  logic [SW-1:0]     sum_q, best_q;
  logic [CB-1:0]     dx_d, dy_d;

  assign dx_d = (ref_e_i >= qry_e_i) ? (ref_e_i - qry_e_i) : (qry_e_i - ref_e_i);
  assign dy_d = (ref_n_i >= qry_n_i) ? (ref_n_i - qry_n_i) : (qry_n_i - ref_n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (ctl_i.start) begin
        found_q <= 1'b0;
      end else if (v3_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    sum_q <= SW'(sqx_q) + SW'(sqy_q);
    // replace only on a strictly smaller value
    if (v3_q && (!found_q || sum_q < best_q)) begin
      best_q <= sum_q;
    end
  end

  assign sts_o.busy  = v1_q | v2_q | v3_q;
  assign sts_o.found = found_q;
  assign best_o      = best_q;

endmodule

/* design/npd_isqrt.sv */
// ---------------------------------------------------------------------------
// Nearest point distance: integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`include "nearest_point_distance_macros.svh"

module npd_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [npd_pkg::SQ_W-1:0]   value_i,
  output logic                       busy_o,
  output logic [npd_pkg::RT_W-1:0]   root_o
);

  localparam int SW = npd_pkg::SQ_W;

  logic [SW-1:0] bit_q, bit_d;
  logic [SW-1:0] v_q, v_d, root_q, root_d, trial;

  assign trial = root_q + bit_q;

  always_comb begin
    bit_d  = bit_q >> 2;
    if (v_q >= trial) begin
      v_d    = v_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end else begin
      v_d    = v_q;
      root_d = root_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= SW'(1) << (SW - 2);
    end else if (bit_q != '0) begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
    end else if (bit_q != '0) begin
      v_q    <= v_d;
      root_q <= root_d;
    end
  end

  assign busy_o = (bit_q != '0);
  assign root_o = npd_pkg::RT_W'(root_q);

  `NPD_ASSERT_IMPL(a_bit_onehot, 1'b1, $onehot0(bit_q))

endmodule

/* design/nearest_point_distance.sv */
// ---------------------------------------------------------------------------
// Nearest point distance
// Brute-force 2-D nearest neighbor over a table of loaded reference points.
// ---------------------------------------------------------------------------
// Clear and load requests complete when accepted. During a query the
// single RAM read port delivers one stored point per cycle to a
// four-stage squared distance pipeline, and the square root unit then
// retires one result bit per cycle. Only one request is in work at a time;
// the result register lets the next request enter while a result waits.
// Loads into a full table are dropped and raise overflowed until a clear.
// A query on an empty table returns distance 0 with table_empty set.
`include "nearest_point_distance_macros.svh"

module nearest_point_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  npd_in_if.sink      req_i,
  npd_out_if.source   rsp_o
);

  localparam int CB = npd_pkg::COORD_BITS;
  localparam int IW = npd_pkg::IDX_W;
  localparam int NW = npd_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]    state_q;
  logic [NW-1:0] cnt_q;
  logic [IW-1:0] idx_q;
  logic          ovf_q, rd_vld_q, out_vld_q;
  logic          empty_q, out_empty_q, out_ovf_q;
  logic [CB-1:0] qry_e_q, qry_n_q;
  logic [npd_pkg::DIST_W-1:0] dist_q;

  logic          acc, ram_we, root_start, root_busy, out_load, full;
  logic [2*CB-1:0] rdata;
  logic [npd_pkg::SQ_W-1:0] best;
  logic [npd_pkg::RT_W-1:0] root;
  npd_pkg::npd_scan_ctl_t   scan_ctl;
  npd_pkg::npd_scan_sts_t   scan_sts;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign full        = (cnt_q == NW'(npd_pkg::MAX_POINTS));
  assign ram_we      = acc && (req_i.mode == npd_pkg::MODE_LOAD) && !full;
  assign root_start  = (state_q == ST_DRAIN) && !rd_vld_q && !scan_sts.busy;
  assign out_load    = (state_q == ST_OUT) && (!out_vld_q || rsp_o.ready);

  assign scan_ctl.start = acc && (req_i.mode == npd_pkg::MODE_QUERY);
  assign scan_ctl.valid = rd_vld_q;

  npd_ram #(
    .WIDTH (2 * CB),
    .DEPTH (npd_pkg::MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({req_i.easting, req_i.northing}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  npd_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .ref_e_i (rdata[2*CB-1:CB]),
    .ref_n_i (rdata[CB-1:0]),
    .qry_e_i (qry_e_q),
    .qry_n_i (qry_n_q),
    .sts_o   (scan_sts),
    .best_o  (best)
  );

  npd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (best),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (req_i.mode)
              npd_pkg::MODE_CLEAR: begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end
              npd_pkg::MODE_LOAD: begin
                // drop the point when full
                if (full) begin
                  ovf_q <= 1'b1;
                end else begin
                  cnt_q <= cnt_q + NW'(1);
                end
              end
              npd_pkg::MODE_QUERY: begin
                idx_q   <= '0;
                state_q <= (cnt_q == '0) ? ST_OUT : ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (NW'(idx_q) == cnt_q - NW'(1)) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (root_start) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (!root_busy) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_ctl.start) begin
      qry_e_q <= req_i.easting;
      qry_n_q <= req_i.northing;
      empty_q <= (cnt_q == '0);
    end
    if (out_load) begin
      dist_q      <= empty_q ? '0 : npd_pkg::DIST_W'(root);
      out_empty_q <= empty_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.distance    = dist_q;
  assign rsp_o.table_empty = out_empty_q;
  assign rsp_o.overflowed  = out_ovf_q;

  `NPD_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= NW'(npd_pkg::MAX_POINTS))
  `NPD_ASSERT_IMPL(a_scan_bound, state_q == ST_SCAN, NW'(idx_q) < cnt_q)
  `NPD_ASSERT_IMPL(a_empty_zero, out_vld_q && out_empty_q, dist_q == '0)
  `NPD_ASSERT_NEXT(a_root_after_scan, root_start, state_q == ST_ROOT && scan_sts.found)

endmodule

/* verif/nearest_point_distance_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Nearest point distance testbench
// Loads reference points, runs nearest distance queries against an in-bench
// scoreboard of the point table, and checks every query result field by field
// under random valid/ready gaps, a long result stall and a full table.
// ---------------------------------------------------------------------------
module nearest_point_distance_tb;

  localparam int         COORD_BITS = npd_pkg::COORD_BITS;
  localparam int         DIST_W     = npd_pkg::DIST_W;
  localparam int         MAX_POINTS = npd_pkg::MAX_POINTS;
  localparam logic [1:0] MODE_CLEAR = npd_pkg::MODE_CLEAR;
  localparam logic [1:0] MODE_LOAD  = npd_pkg::MODE_LOAD;
  localparam logic [1:0] MODE_QUERY = npd_pkg::MODE_QUERY;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned QUIET_FROM  = 3000;
  localparam int unsigned QUIET_TO    = 9000;
  localparam int unsigned HOLD_AT     = 5000;
  localparam int unsigned HOLD_LEN    = 600;
  localparam int unsigned STALL_LIMIT = 30000;
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] east;
    logic [COORD_BITS-1:0] north;
    logic                  drain_first;  // wait for all results before sending
  } point_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              table_empty;
    logic              overflowed;
  } dist_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  npd_in_if  req_if ();
  npd_out_if rsp_if ();

  nearest_point_distance u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  point_req_t  point_req_q[$];
  dist_res_t   dist_expect_q[$];
  point_req_t  cur_req;
  point_req_t  acc_req;
  logic        acc_valid;
  logic        results_idle;
  int unsigned err_cnt;
  int unsigned cyc_cnt;
  int unsigned idle_cyc;
  int unsigned hold_left;
  logic        hold_done;
  logic        quiet;

  // scoreboard copy of the point table
  logic [COORD_BITS-1:0] tbl_east [MAX_POINTS];
  logic [COORD_BITS-1:0] tbl_north[MAX_POINTS];
  int unsigned           tbl_count;
  logic                  tbl_ovf;

  // stimulus-side view of the table, used to aim queries
  int unsigned           gen_items;
  logic [COORD_BITS-1:0] gen_e[$];
  logic [COORD_BITS-1:0] gen_n[$];

  assign quiet = (cyc_cnt >= QUIET_FROM) && (cyc_cnt < QUIET_TO);

  function automatic logic [DIST_W-1:0] floor_root(input logic [63:0] v);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] cand;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = root | (DIST_W'(1) << b);
      if (64'(cand) * 64'(cand) <= v) root = cand;
    end
    return root;
  endfunction

  task automatic predict_nearest(input point_req_t r);
    logic [63:0]           best;
    logic [63:0]           sq;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    dist_res_t             res;
    case (r.mode)
      MODE_CLEAR: begin
        tbl_count = 0;
        tbl_ovf   = 1'b0;
      end
      MODE_LOAD: begin
        if (tbl_count < MAX_POINTS) begin
          tbl_east[tbl_count]  = r.east;
          tbl_north[tbl_count] = r.north;
          tbl_count++;
        end else begin
          tbl_ovf = 1'b1;
        end
      end
      MODE_QUERY: begin
        best = '1;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          dx = (tbl_east[i] >= r.east) ? tbl_east[i] - r.east : r.east - tbl_east[i];
          dy = (tbl_north[i] >= r.north) ? tbl_north[i] - r.north : r.north - tbl_north[i];
          sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
          if (i == 0 || sq < best) best = sq;
        end
        res.table_empty = (tbl_count == 0);
        res.distance    = (tbl_count == 0) ? '0 : floor_root(best);
        res.overflowed  = tbl_ovf;
        dist_expect_q = {dist_expect_q, res};
      end
      default: ;  // unused mode leaves the table alone
    endcase
  endtask

  task automatic add_req(input logic [1:0] m, input logic [COORD_BITS-1:0] e,
                         input logic [COORD_BITS-1:0] n, input logic drain);
    point_req_t r;
    r.mode        = m;
    r.east        = e;
    r.north       = n;
    r.drain_first = drain;
    point_req_q = {point_req_q, r};
    if (m != MODE_UNUSED) gen_items++;
    if (m == MODE_CLEAR) begin
      gen_e.delete();
      gen_n.delete();
    end else if (m == MODE_LOAD && gen_e.size() < MAX_POINTS) begin
      gen_e = {gen_e, e};
      gen_n = {gen_n, n};
    end
  endtask

  function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] v);
    int s;
    s = int'(v) + int'($urandom_range(600)) - 300;
    if (s < 0) s = 0;
    if (s > int'(COORD_MAX)) s = int'(COORD_MAX);
    return COORD_BITS'(s);
  endfunction

  task automatic add_load();
    int unsigned           k;
    logic [COORD_BITS-1:0] e;
    logic [COORD_BITS-1:0] n;
    e = COORD_BITS'($urandom);
    n = COORD_BITS'($urandom);
    // repeat or crowd an earlier point now and then to force ties
    if (gen_e.size() != 0 && $urandom_range(99) < 15) begin
      k = $urandom_range(gen_e.size() - 1);
      e = gen_e[k];
      n = gen_n[k];
      if ($urandom_range(1) == 1) begin
        e = nudge(e);
        n = nudge(n);
      end
    end
    add_req(MODE_LOAD, e, n, 1'b0);
  endtask

  task automatic add_query();
    int unsigned           k;
    int unsigned           sel;
    logic [COORD_BITS-1:0] e;
    logic [COORD_BITS-1:0] n;
    sel = $urandom_range(99);
    e   = COORD_BITS'($urandom);
    n   = COORD_BITS'($urandom);
    if (gen_e.size() != 0 && sel < 50) begin
      k = $urandom_range(gen_e.size() - 1);
      e = gen_e[k];
      n = gen_n[k];
      if (sel < 35) begin
        e = nudge(e);
        n = nudge(n);
      end
    end else if (sel < 60) begin
      e = ($urandom_range(1) == 1) ? COORD_MAX : '0;
      n = ($urandom_range(1) == 1) ? COORD_MAX : '0;
    end
    add_req(MODE_QUERY, e, n, 1'b0);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    logic       fire;
    logic       drained;
    point_req_t nxt;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.mode     <= MODE_CLEAR;
      req_if.easting  <= '0;
      req_if.northing <= '0;
      cur_req         <= '0;
      acc_req         <= '0;
      acc_valid       <= 1'b0;
    end else begin
      fire    = req_if.valid && req_if.ready;
      drained = !fire && !acc_valid && results_idle;
      acc_valid <= fire;
      if (fire) acc_req <= cur_req;
      if (fire || !req_if.valid) begin
        if (point_req_q.size() != 0 && (quiet || $urandom_range(99) >= 37) &&
            (!point_req_q[0].drain_first || drained)) begin
          nxt = point_req_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.mode     <= nxt.mode;
          req_if.easting  <= nxt.east;
          req_if.northing <= nxt.north;
          cur_req         <= nxt;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with one long hold-off inside the quiet window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && cyc_cnt == HOLD_AT) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_LEN;
      hold_done    <= 1'b1;
    end else begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 37);
    end
  end

  // result monitor: predict last cycle's request, then check this cycle's result
  always @(posedge clk_i or negedge rst_ni) begin : check_rsp
    dist_res_t want;
    if (!rst_ni) begin
      results_idle <= 1'b1;
    end else begin
      if (acc_valid) predict_nearest(acc_req);
      if (rsp_if.valid && rsp_if.ready) begin
        if (dist_expect_q.size() == 0) begin
          $display("%0t: unexpected result distance %0d table_empty %0b overflowed %0b",
                   $time, rsp_if.distance, rsp_if.table_empty, rsp_if.overflowed);
          err_cnt++;
        end else begin
          want = dist_expect_q.pop_front();
          if (rsp_if.distance !== want.distance) begin
            $display("%0t: distance expected %0d, got %0d",
                     $time, want.distance, rsp_if.distance);
            err_cnt++;
          end
          if (rsp_if.table_empty !== want.table_empty) begin
            $display("%0t: table_empty expected %0b, got %0b",
                     $time, want.table_empty, rsp_if.table_empty);
            err_cnt++;
          end
          if (rsp_if.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b, got %0b",
                     $time, want.overflowed, rsp_if.overflowed);
            err_cnt++;
          end
        end
      end
      results_idle <= (dist_expect_q.size() == 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cyc_cnt <= 0;
    else         cyc_cnt <= cyc_cnt + 1;
  end

  // abort when no request or result moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cyc <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cyc);
      $display("FAIL nearest_point_distance");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned npts;
    int unsigned nq;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_CLEAR;
    req_if.easting  = '0;
    req_if.northing = '0;
    rsp_if.ready    = 1'b0;
    err_cnt         = 0;
    gen_items       = 0;
    tbl_count       = 0;
    tbl_ovf         = 1'b0;

    // directed: empty table, extremes, ties, ignored mode, clear
    add_req(MODE_QUERY,  '0, '0, 1'b0);
    add_req(MODE_UNUSED, COORD_MAX, COORD_MAX, 1'b0);
    add_req(MODE_QUERY,  COORD_MAX, COORD_MAX, 1'b0);
    add_req(MODE_LOAD,   '0, '0, 1'b0);
    add_req(MODE_QUERY,  COORD_MAX, COORD_MAX, 1'b0);
    add_req(MODE_QUERY,  '0, '0, 1'b0);
    add_req(MODE_LOAD,   COORD_MAX, COORD_MAX, 1'b0);
    add_req(MODE_LOAD,   '0, '0, 1'b0);
    add_req(MODE_QUERY,  '0, '0, 1'b0);
    add_req(MODE_QUERY,  24'h800000, 24'h800000, 1'b0);
    add_req(MODE_QUERY,  COORD_MAX, '0, 1'b0);
    add_req(MODE_UNUSED, 24'h123456, 24'h654321, 1'b0);
    add_req(MODE_QUERY,  24'h123456, 24'h654321, 1'b0);
    add_req(MODE_CLEAR,  COORD_MAX, COORD_MAX, 1'b0);
    add_req(MODE_QUERY,  24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_req(MODE_LOAD,   24'hAAAAAA, 24'h555555, 1'b0);
    add_req(MODE_LOAD,   24'h555555, 24'hAAAAAA, 1'b0);
    add_req(MODE_QUERY,  COORD_MAX, '0, 1'b0);
    add_req(MODE_QUERY,  '0, COORD_MAX, 1'b0);
    add_req(MODE_CLEAR,  '0, '0, 1'b1);
    add_req(MODE_QUERY,  '0, '0, 1'b0);

    // random: mostly clear, load a few points, then aim queries at them
    while (gen_items < 560) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        add_req(MODE_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                $urandom_range(9) == 0);
        npts = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
        repeat (npts) add_load();
        nq = $urandom_range(5, 1);
        repeat (nq) begin
          if ($urandom_range(3) == 0) add_load();
          add_query();
        end
      end else begin
        case ($urandom_range(3))
          0:       add_req(MODE_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
          1:       add_query();
          2:       add_load();
          default: add_req(MODE_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
        endcase
      end
    end

    // full table, then loads past capacity, then clear drops the overflow
    add_req(MODE_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1);
    repeat (MAX_POINTS) add_load();
    add_query();
    add_query();
    add_req(MODE_QUERY, COORD_MAX, COORD_MAX, 1'b0);
    repeat (4) add_req(MODE_LOAD, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
    add_query();
    add_req(MODE_QUERY, '0, '0, 1'b0);
    add_req(MODE_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
    add_query();
    add_load();
    add_query();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (point_req_q.size() != 0 || req_if.valid || acc_valid || !results_idle)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (dist_expect_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, dist_expect_q.size());
    if (err_cnt == 0 && dist_expect_q.size() == 0) begin
      $display("PASS nearest_point_distance");
    end else begin
      $display("FAIL nearest_point_distance");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/npd_pkg.sv
design/npd_in_if.sv
design/npd_out_if.sv
design/npd_ram.sv
design/npd_dist.sv
design/npd_isqrt.sv
design/nearest_point_distance.sv
verif/nearest_point_distance_tb.sv
